FILE: rtl/tdal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdal_pkg
// types and constants shared by the tree distance block
// ----------------------------------------------------------------------------
package tdal_pkg;

	localparam int NODE_W   = 10;
	localparam int MAX_NODES = 1 << NODE_W;
	localparam int LEVELS   = 10;
	localparam int LVL_W    = 4;
	localparam int DEPTH_W  = 10;
	localparam int DIST_W   = 11;
	localparam int ANC_AW   = NODE_W + LVL_W;

	localparam logic [DEPTH_W-1:0] DEPTH_SAT = {DEPTH_W{1'b1}};
	localparam logic [DIST_W-1:0]  DIST_MAX  = DIST_W'(2046);
	localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(LEVELS - 1);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_LOADED = 2'd1,
		STAT_NO_PARENT  = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic              is_root;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		status_t           status;
	} rsp_t;

	// one ancestor table entry
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} anc_t;

	// one node info entry
	typedef struct packed {
		logic               loaded;
		logic [DEPTH_W-1:0] depth;
	} info_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_PAR,
		S_LD_WR,
		S_LD_RD,
		S_LD_NX,
		S_Q_A,
		S_Q_B,
		S_L1,
		S_L1W,
		S_CMP,
		S_P2X,
		S_P2Y,
		S_P2C,
		S_FX,
		S_FY,
		S_FC,
		S_DL,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/tree_distance_by_ancestor_lifting.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tree_distance_by_ancestor_lifting
// rooted tree store with ancestor lifting and path distance queries
// ----------------------------------------------------------------------------
// The tree lives in two memories, each with one write port and one registered
// read port: a node info memory (loaded flag and depth, 1024 entries) and an
// ancestor table (one row of 10 power-of-two ancestors per node). After reset
// the block runs a clearing pass over all 1024 node info entries and stalls
// requests meanwhile. Items are handled one at a time; each read of either
// memory is registered. A load reads the parent's info; for a root or a
// loaded parent it writes the node's info, then walks the levels, writing
// each ancestor entry and, while one exists, reading the next from the table.
// A query of a node not loaded ends after both info reads. Otherwise a query
// lifts the deeper node by the set bits of the depth difference; when it
// lands on the other one the distance follows, else a second lifting phase
// over 10 levels and a final parent check come first. The block returns to
// idle before the next request is taken. The result sits in an output
// register, so the next request is taken while a result beat waits.
// ----------------------------------------------------------------------------
module tree_distance_by_ancestor_lifting (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire tdal_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tdal_pkg::rsp_t     rsp
);

	import tdal_pkg::*;

	state_t state_q, state_d;

	// request and working registers
	req_t               req_q;
	logic [NODE_W-1:0]  clr_q;
	logic [LVL_W-1:0]   lvl_q;
	anc_t               cur_q;
	anc_t               ax_q;
	logic [NODE_W-1:0]  x_q, y_q;
	logic [DEPTH_W-1:0] dx_q, dy_q, diff_q, da_q;
	rsp_t               res_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// memory ports
	logic              info_we;
	logic [NODE_W-1:0] info_waddr, info_raddr;
	info_t             info_wdata, info_rd;
	logic              anc_we;
	logic [ANC_AW-1:0] anc_waddr, anc_raddr;
	anc_t              anc_rd;

	logic               accept;
	logic               out_free;
	logic [DEPTH_W-1:0] par_depth;
	logic [DIST_W:0]    total;

	tdal_ram #(.ADDR_W(NODE_W), .DATA_W($bits(info_t))) u_info (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (info_wdata),
		.raddr (info_raddr),
		.rdata (info_rd)
	);

	tdal_ram #(.ADDR_W(ANC_AW), .DATA_W($bits(anc_t))) u_anc (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_waddr),
		.wdata (cur_q),
		.raddr (anc_raddr),
		.rdata (anc_rd)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// child depth saturates at the top of the depth range
	assign par_depth = (info_rd.depth == DEPTH_SAT) ? DEPTH_SAT : info_rd.depth + 1'b1;

	// depth a plus depth b minus twice the lca depth, signed
	assign total = {2'b00, dx_q} + {2'b00, dy_q} - {1'b0, info_rd.depth, 1'b0};

	// next state and memory control
	always_comb begin
		state_d    = state_q;
		info_we    = 1'b0;
		info_waddr = req_q.node_a;
		info_wdata = '{loaded: 1'b1, depth: par_depth};
		info_raddr = req_q.node_b;
		anc_we     = 1'b0;
		anc_waddr  = {req_q.node_a, lvl_q};
		anc_raddr  = {x_q, lvl_q};
		unique case (state_q)
			S_CLEAR: begin
				info_we    = 1'b1;
				info_waddr = clr_q;
				info_wdata = '0;
				if (clr_q == NODE_W'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				info_raddr = (req.opcode == OP_LOAD) ? req.node_b : req.node_a;
				if (accept) begin
					state_d = (req.opcode == OP_LOAD) ? S_LD_PAR : S_Q_A;
				end
			end
			S_LD_PAR: begin
				if (req_q.is_root) begin
					info_we    = 1'b1;
					info_wdata = '{loaded: 1'b1, depth: '0};
					state_d    = S_LD_WR;
				end else if (info_rd.loaded) begin
					info_we = 1'b1;
					state_d = S_LD_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LD_WR: begin
				anc_we = 1'b1;
				if (lvl_q == LVL_LAST) begin
					state_d = S_DONE;
				end else if (cur_q.valid) begin
					state_d = S_LD_RD;
				end
			end
			S_LD_RD: begin
				anc_raddr = {cur_q.node, lvl_q};
				state_d   = S_LD_NX;
			end
			S_LD_NX: state_d = S_LD_WR;
			S_Q_A:   state_d = S_Q_B;
			S_Q_B: begin
				state_d = (info_rd.loaded && ax_q.valid) ? S_L1 : S_DONE;
			end
			S_L1: begin
				if (diff_q[lvl_q]) begin
					state_d = S_L1W;
				end else if (lvl_q == LVL_LAST) begin
					state_d = S_CMP;
				end
			end
			S_L1W: begin
				if (!anc_rd.valid || lvl_q == LVL_LAST) begin
					state_d = S_CMP;
				end else begin
					state_d = S_L1;
				end
			end
			S_CMP: begin
				info_raddr = x_q;
				state_d    = (x_q == y_q) ? S_DL : S_P2X;
			end
			S_P2X: state_d = S_P2Y;
			S_P2Y: begin
				anc_raddr = {y_q, lvl_q};
				state_d   = S_P2C;
			end
			S_P2C: state_d = (lvl_q == '0) ? S_FX : S_P2X;
			S_FX: begin
				anc_raddr = {x_q, {LVL_W{1'b0}}};
				state_d   = S_FY;
			end
			S_FY: begin
				anc_raddr = {y_q, {LVL_W{1'b0}}};
				state_d   = S_FC;
			end
			S_FC: begin
				info_raddr = ax_q.node;
				if (ax_q.valid && anc_rd.valid && ax_q.node == anc_rd.node) begin
					state_d = S_DL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DL:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req;
				res_q <= '{distance: '0, status: STAT_OK};
			end
			S_LD_PAR: begin
				lvl_q <= '0;
				if (req_q.is_root) begin
					cur_q <= '0;
				end else begin
					cur_q <= '{valid: 1'b1, node: req_q.node_b};
					if (!info_rd.loaded) begin
						res_q.status <= STAT_NO_PARENT;
					end
				end
			end
			S_LD_WR: begin
				if (!cur_q.valid) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_LD_RD: lvl_q <= lvl_q + 1'b1;
			S_LD_NX: cur_q <= anc_rd;
			S_Q_A: begin
				da_q     <= info_rd.depth;
				ax_q.valid <= info_rd.loaded;
			end
			S_Q_B: begin
				lvl_q <= '0;
				if (!(info_rd.loaded && ax_q.valid)) begin
					res_q.status <= STAT_NOT_LOADED;
				end
				if (da_q < info_rd.depth) begin
					x_q    <= req_q.node_b;
					y_q    <= req_q.node_a;
					dx_q   <= info_rd.depth;
					dy_q   <= da_q;
					diff_q <= info_rd.depth - da_q;
				end else begin
					x_q    <= req_q.node_a;
					y_q    <= req_q.node_b;
					dx_q   <= da_q;
					dy_q   <= info_rd.depth;
					diff_q <= da_q - info_rd.depth;
				end
			end
			S_L1: begin
				if (!diff_q[lvl_q] && lvl_q != LVL_LAST) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_L1W: begin
				if (anc_rd.valid) begin
					x_q <= anc_rd.node;
					if (lvl_q != LVL_LAST) begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
			end
			S_CMP:  lvl_q <= LVL_LAST;
			S_P2Y:  ax_q <= anc_rd;
			S_P2C: begin
				if (ax_q.valid && anc_rd.valid && ax_q.node != anc_rd.node) begin
					x_q <= ax_q.node;
					y_q <= anc_rd.node;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - 1'b1;
				end
			end
			S_FY:   ax_q <= anc_rd;
			S_FC: begin
				if (!(ax_q.valid && anc_rd.valid && ax_q.node == anc_rd.node)) begin
					res_q.status <= STAT_NOT_LOADED;
				end
			end
			S_DL: begin
				if (total[DIST_W]) begin
					res_q.distance <= '0;
				end else if (total[DIST_W-1:0] > DIST_MAX) begin
					res_q.distance <= DIST_MAX;
				end else begin
					res_q.distance <= total[DIST_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted request left block idle");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !rsp_valid)
		else $error("result during clearing pass");
	a_parent_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status == STAT_NO_PARENT) |-> (req_q.opcode == OP_LOAD))
		else $error("parent error on a query");
	a_dist_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.distance != '0) |-> (res_q.status == STAT_OK))
		else $error("nonzero distance with error status");
`endif

endmodule
`default_nettype wire

FILE: rtl/tdal_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdal_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module tdal_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 11
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
